/* design/grm_pkg.sv */
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types, constants and arithmetic helpers of the grid ray marcher:
// command codes, grid geometry, angle folding and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package grm_pkg;

    // Grid geometry (square, power of two)
    localparam int GRID      = 64;
    localparam int GridBits  = $clog2(GRID);
    localparam int MapDepth  = GRID * GRID;
    localparam int MapAw     = 2 * GridBits;

    // Ray accumulator: Q24 coordinates, room for one sign bit and one overflow bit
    localparam int FracC     = 24;
    localparam int AccW      = FracC + GridBits + 2;

    // Angles in eighths of a degree
    localparam int FullTurn  = 2880;
    localparam int Quarter   = 720;
    localparam int AngW      = 12;

    localparam logic [13:0] StepMax = 14'h3FFF;

    // Register map, by register index
    localparam logic [1:0] RegTurnStep  = 2'd0;
    localparam logic [1:0] RegMoveStep  = 2'd1;
    localparam logic [1:0] RegMarchStep = 2'd2;

    localparam logic [10:0] TurnStepRst  = 11'd20;
    localparam logic [9:0]  MoveStepRst  = 10'd102;
    localparam logic [9:0]  MarchStepRst = 10'd51;

    // Command codes
    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_SETPOS = 3'd1,
        CMD_TURN   = 3'd2,
        CMD_MOVE   = 3'd3,
        CMD_CAST   = 3'd4
    } t_cmd;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROM_COS,
        ST_ROM_SIN,
        ST_LATCH_SIN,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MOVE_ADDR,
        ST_MOVE_CHK,
        ST_CAST_STEP,
        ST_CAST_CHK,
        ST_DONE
    } t_state;

    // Folded table access: table address and sign of the result
    typedef struct packed {
        logic [9:0] addr;
        logic       neg;
    } t_rom_sel;

    typedef logic [14:0] t_sine_tab [Quarter + 1];

    // Taylor series divisors, innermost term first
    localparam logic [63:0] TaylorDiv [6] = '{64'd156, 64'd110, 64'd72, 64'd42,
                                             64'd20, 64'd6};
    localparam logic [63:0] PiQ30  = 64'd3373259426;
    localparam logic [63:0] OneQ30 = 64'd1073741824;
    localparam logic [63:0] HalfPiDen = 64'd1440;

    // Build the quarter-wave sine table in Q1.14 at elaboration
    function automatic t_sine_tab build_sine();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        for (int k = 0; k <= Quarter; k++) begin
            x  = (64'(k) * PiQ30 + 64'(Quarter)) / HalfPiDen;
            x2 = (x * x) >> 30;
            t  = OneQ30;
            for (int i = 0; i < 6; i++) begin
                t = OneQ30 - (((x2 * t) >> 30) / TaylorDiv[i]);
            end
            s = (x * t) >> 30;
            e = (s + 64'd32768) >> 16;
            tab[k] = e[14:0];
        end
        return tab;
    endfunction

    // Reduce an angle below two full turns into one turn
    function automatic logic [AngW-1:0] red_angle(logic [AngW:0] a);
        logic [AngW:0] d;
        d = a - (AngW+1)'(FullTurn);
        return (a >= (AngW+1)'(FullTurn)) ? d[AngW-1:0] : a[AngW-1:0];
    endfunction

    // Fold an angle of one turn onto the quarter-wave table
    function automatic t_rom_sel fold_angle(logic [AngW-1:0] a);
        t_rom_sel      sel;
        logic [AngW-1:0] r;
        logic [1:0]    q;
        if (a >= AngW'(3 * Quarter)) begin
            q = 2'd3;
            r = a - AngW'(3 * Quarter);
        end else if (a >= AngW'(2 * Quarter)) begin
            q = 2'd2;
            r = a - AngW'(2 * Quarter);
        end else if (a >= AngW'(Quarter)) begin
            q = 2'd1;
            r = a - AngW'(Quarter);
        end else begin
            q = 2'd0;
            r = a;
        end
        sel.addr = q[0] ? 10'(AngW'(Quarter) - r) : r[9:0];
        sel.neg  = q[1];
        return sel;
    endfunction

    // Scale a product of trig and step back to Q10, half away from zero
    function automatic logic signed [11:0] round_q10(logic signed [25:0] p);
        logic [25:0] mag;
        logic [25:0] sum;
        logic [11:0] r;
        mag = p[25] ? 26'(-p) : 26'(p);
        sum = mag + 26'd8192;
        r   = {1'b0, sum[24:14]};
        return p[25] ? signed'(12'(-r)) : signed'(r);
    endfunction

endpackage

`default_nettype wire

/* design/grm_if.sv */
// ----------------------------------------------------------------------------
// grm_in_if / grm_out_if
// Valid/ready channels of the grid ray marcher: command items in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface grm_in_if;
    import grm_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       cmd;
    logic [5:0]       cell_row;
    logic [5:0]       cell_col;
    logic             wall;
    logic [15:0]      new_x;
    logic [15:0]      new_y;
    logic [1:0]       direction;
    logic [AngW-1:0]  ray_angle;

    modport source (output valid, cmd, cell_row, cell_col, wall, new_x, new_y,
                    direction, ray_angle, input ready);
    modport sink   (input valid, cmd, cell_row, cell_col, wall, new_x, new_y,
                    direction, ray_angle, output ready);
endinterface

interface grm_out_if;
    import grm_pkg::*;
    logic             valid;
    logic             ready;
    logic [13:0]      hit_steps;
    logic             saturated;
    logic             moved;
    logic [AngW-1:0]  heading;
    logic [15:0]      pos_x;
    logic [15:0]      pos_y;

    modport source (output valid, hit_steps, saturated, moved, heading, pos_x, pos_y,
                    input ready);
    modport sink   (input valid, hit_steps, saturated, moved, heading, pos_x, pos_y,
                    output ready);
endinterface

`default_nettype wire

/* design/grm_sine_rom.sv */
// ----------------------------------------------------------------------------
// grm_sine_rom
// Quarter-wave sine table, Q1.14, 721 entries, one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grm_sine_rom (
    input  wire logic        i_clk,
    input  wire logic [9:0]  i_addr,
    output logic      [14:0] o_data
);
    import grm_pkg::*;

    localparam t_sine_tab SineTab = build_sine();

    logic [14:0] r_data;

    // Registered table read
    always_ff @(posedge i_clk) begin
        r_data <= SineTab[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* design/grid_ray_marcher.sv */
// ----------------------------------------------------------------------------
// grid_ray_marcher
// Wall map, viewer position and heading with write, set, turn, move and
// fixed-step ray cast commands, run by a small sequencer around one
// multiplier, one table port and one map write and one map read port.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  i_in     in   valid/ready          cmd, cell, wall, new pos, direction, angle
//  o_out    out  valid/ready          hit_steps, saturated, moved, heading, pos
//  apb      in   psel/penable/pready  turn_step, move_step, march_step
//
//  After reset a clearing pass sweeps the 4096-cell map, one cell a cycle,
//  before the first transaction is taken. One item is in flight at a time:
//  write, set position and turn go straight to done; a move reads cosine and
//  sine, scales them by the step and checks the target cell; a cast reads and
//  scales alike, then marches with one map read per step. A result sits in
//  the output register until taken; the input stays stalled while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_marcher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    grm_in_if.sink           i_in,
    grm_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import grm_pkg::*;

    t_state                  r_state, n_state;
    logic [10:0]             r_turn_step;
    logic [9:0]              r_move_step, r_march_step;
    logic [15:0]             r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [AngW-1:0]         r_heading, n_heading;
    logic [2:0]              r_cmd, n_cmd;
    logic [1:0]              r_dir, n_dir;
    logic [AngW-1:0]         r_angle, n_angle;
    logic                    r_neg, n_neg;
    logic signed [15:0]      r_cos, n_cos, r_sin, n_sin;
    logic signed [25:0]      r_px, n_px, r_py, n_py;
    logic signed [AccW-1:0]  r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic [13:0]             r_steps, n_steps;
    logic                    r_oob, n_oob;
    logic signed [17:0]      r_tx, n_tx, r_ty, n_ty;
    logic                    r_tok, n_tok;
    logic                    r_moved, n_moved;
    logic                    r_out_valid, n_out_valid;
    logic [13:0]             r_o_hits, n_o_hits;
    logic                    r_o_sat, n_o_sat;
    logic                    r_o_moved, n_o_moved;
    logic [MapAw-1:0]        r_clr_addr, n_clr_addr;

    logic                    accept;
    logic                    cfg_wr;
    logic [9:0]              rom_addr;
    logic [14:0]             rom_q;
    logic signed [15:0]      rom_val;
    t_rom_sel                cos_sel, sin_sel;
    logic signed [15:0]      mul_a;
    logic signed [10:0]      mul_b;
    logic signed [26:0]      mul_p;
    logic signed [11:0]      cx, cy, dx, dy;
    logic signed [AccW-1:0]  sum_x, sum_y;
    logic                    map_we, map_wd, map_q;
    logic [MapAw-1:0]        map_wa, map_ra;
    logic                    mem [MapDepth];
    logic                    r_map_q;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) && !r_out_valid;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            RegTurnStep:  prdata = {21'b0, r_turn_step};
            RegMoveStep:  prdata = {22'b0, r_move_step};
            RegMarchStep: prdata = {22'b0, r_march_step};
            default:      prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_step  <= TurnStepRst;
            r_move_step  <= MoveStepRst;
            r_march_step <= MarchStepRst;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                RegTurnStep:  r_turn_step  <= pwdata[10:0];
                RegMoveStep:  r_move_step  <= pwdata[9:0];
                RegMarchStep: r_march_step <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Sine table
    grm_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_q)
    );

    assign cos_sel = fold_angle(red_angle((AngW+1)'(r_angle) + (AngW+1)'(Quarter)));
    assign sin_sel = fold_angle(r_angle);
    assign rom_addr = (r_state == ST_ROM_COS) ? cos_sel.addr : sin_sel.addr;
    assign rom_val  = r_neg ? -signed'({1'b0, rom_q}) : signed'({1'b0, rom_q});

    // Shared multiplier: trig value times the step of the command
    assign mul_a = (r_state == ST_MUL_X) ? r_cos : r_sin;
    assign mul_b = signed'({1'b0, (r_cmd == CMD_MOVE) ? r_move_step : r_march_step});
    assign mul_p = mul_a * mul_b;

    // Move target offsets
    assign cx = round_q10(r_px);
    assign cy = round_q10(r_py);

    always_comb begin
        case (r_dir)
            2'd0: begin dx = cx;  dy = cy;  end
            2'd1: begin dx = -cx; dy = -cy; end
            2'd2: begin dx = cy;  dy = -cx; end
            2'd3: begin dx = -cy; dy = cx;  end
            default: begin dx = cx; dy = cy; end
        endcase
    end

    // Ray accumulator advance
    assign sum_x = r_acc_x + AccW'(r_px);
    assign sum_y = r_acc_y + AccW'(r_py);

    // Wall map: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem[map_wa] <= map_wd;
        end
        r_map_q <= mem[map_ra];
    end
    assign map_q = r_map_q;

    always_comb begin
        map_we = 1'b0;
        map_wa = r_clr_addr;
        map_wd = 1'b0;
        if (r_state == ST_CLEAR) begin
            map_we = 1'b1;
        end else if (accept && i_in.cmd == CMD_WRITE &&
                     int'(i_in.cell_row) < GRID && int'(i_in.cell_col) < GRID) begin
            map_we = 1'b1;
            map_wa = {i_in.cell_row[GridBits-1:0], i_in.cell_col[GridBits-1:0]};
            map_wd = i_in.wall;
        end
    end

    always_comb begin
        if (r_state == ST_CAST_STEP) begin
            map_ra = {sum_y[FracC+GridBits-1:FracC], sum_x[FracC+GridBits-1:FracC]};
        end else begin
            map_ra = {n_ty[10+GridBits-1:10], n_tx[10+GridBits-1:10]};
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:     if (r_clr_addr == MapAw'(MapDepth - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.cmd == CMD_MOVE || i_in.cmd == CMD_CAST) begin
                        n_state = ST_ROM_COS;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_ROM_COS:   n_state = ST_ROM_SIN;
            ST_ROM_SIN:   n_state = ST_LATCH_SIN;
            ST_LATCH_SIN: n_state = ST_MUL_X;
            ST_MUL_X:     n_state = ST_MUL_Y;
            ST_MUL_Y:     n_state = (r_cmd == CMD_MOVE) ? ST_MOVE_ADDR : ST_CAST_STEP;
            ST_MOVE_ADDR: n_state = ST_MOVE_CHK;
            ST_MOVE_CHK:  n_state = ST_DONE;
            ST_CAST_STEP: n_state = ST_CAST_CHK;
            ST_CAST_CHK: begin
                if (r_oob || map_q || r_steps == StepMax) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CAST_STEP;
                end
            end
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Datapath updates per state
    always_comb begin
        logic [AngW:0] turn_sum;
        turn_sum    = '0;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_heading   = r_heading;
        n_cmd       = r_cmd;
        n_dir       = r_dir;
        n_angle     = r_angle;
        n_neg       = r_neg;
        n_cos       = r_cos;
        n_sin       = r_sin;
        n_px        = r_px;
        n_py        = r_py;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_steps     = r_steps;
        n_oob       = r_oob;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_tok       = r_tok;
        n_moved     = r_moved;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_hits    = r_o_hits;
        n_o_sat     = r_o_sat;
        n_o_moved   = r_o_moved;
        n_clr_addr  = r_clr_addr;
        case (r_state)
            ST_CLEAR: n_clr_addr = r_clr_addr + MapAw'(1);
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_in.cmd;
                    n_dir   = i_in.direction;
                    n_steps = '0;
                    n_moved = 1'b0;
                    n_angle = (i_in.cmd == CMD_CAST) ? red_angle({1'b0, i_in.ray_angle})
                                                     : r_heading;
                    if (i_in.cmd == CMD_SETPOS) begin
                        n_pos_x = i_in.new_x;
                        n_pos_y = i_in.new_y;
                    end
                    if (i_in.cmd == CMD_TURN) begin
                        if (i_in.direction[0]) begin
                            turn_sum = (AngW+1)'(r_heading) + (AngW+1)'(r_turn_step);
                        end else begin
                            turn_sum = (AngW+1)'(r_heading) + (AngW+1)'(FullTurn)
                                       - (AngW+1)'(r_turn_step);
                        end
                        n_heading = red_angle(turn_sum);
                    end
                end
            end
            ST_ROM_COS: n_neg = cos_sel.neg;
            ST_ROM_SIN: begin
                n_cos = rom_val;
                n_neg = sin_sel.neg;
            end
            ST_LATCH_SIN: n_sin = rom_val;
            ST_MUL_X: n_px = mul_p[25:0];
            ST_MUL_Y: begin
                n_py    = mul_p[25:0];
                n_acc_x = AccW'({r_pos_x, 14'b0});
                n_acc_y = AccW'({r_pos_y, 14'b0});
                n_steps = 14'd1;
            end
            ST_MOVE_ADDR: begin
                n_tx  = signed'({2'b0, r_pos_x}) + 18'(dx);
                n_ty  = signed'({2'b0, r_pos_y}) + 18'(dy);
                n_tok = (n_tx[17:16] == 2'b00) && (n_ty[17:16] == 2'b00) &&
                        (int'(n_tx[15:10]) < GRID) && (int'(n_ty[15:10]) < GRID);
            end
            ST_MOVE_CHK: begin
                if (r_tok && !map_q) begin
                    n_pos_x = r_tx[15:0];
                    n_pos_y = r_ty[15:0];
                    n_moved = 1'b1;
                end
            end
            ST_CAST_STEP: begin
                n_acc_x = sum_x;
                n_acc_y = sum_y;
                n_oob   = sum_x[AccW-1] || sum_y[AccW-1] ||
                          (int'(sum_x[AccW-2:FracC]) >= GRID) ||
                          (int'(sum_y[AccW-2:FracC]) >= GRID);
            end
            ST_CAST_CHK: begin
                if (!(r_oob || map_q || r_steps == StepMax)) begin
                    n_steps = r_steps + 14'd1;
                end
            end
            ST_DONE: begin
                // Step count is reported for a cast only
                n_out_valid = 1'b1;
                n_o_hits    = (r_cmd == CMD_CAST) ? r_steps : 14'd0;
                n_o_sat     = (r_cmd == CMD_CAST) && (r_steps == StepMax);
                n_o_moved   = r_moved;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_dir     <= n_dir;
        r_angle   <= n_angle;
        r_neg     <= n_neg;
        r_cos     <= n_cos;
        r_sin     <= n_sin;
        r_px      <= n_px;
        r_py      <= n_py;
        r_acc_x   <= n_acc_x;
        r_acc_y   <= n_acc_y;
        r_steps   <= n_steps;
        r_oob     <= n_oob;
        r_tx      <= n_tx;
        r_ty      <= n_ty;
        r_tok     <= n_tok;
        r_moved   <= n_moved;
        r_o_hits  <= n_o_hits;
        r_o_sat   <= n_o_sat;
        r_o_moved <= n_o_moved;
    end

    // Result channel
    assign o_out.valid     = r_out_valid;
    assign o_out.hit_steps = r_o_hits;
    assign o_out.saturated = r_o_sat;
    assign o_out.moved     = r_o_moved;
    assign o_out.heading   = r_heading;
    assign o_out.pos_x     = r_pos_x;
    assign o_out.pos_y     = r_pos_y;

endmodule

`default_nettype wire
